// File: hdl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared widths, witness base table and the modular multiplier request type.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  // Width of the candidate and of every residue.
  localparam int unsigned CandW = 63;
  // Width of a witness base constant.
  localparam int unsigned BaseW = 31;
  // Number of witness bases and the width of their index.
  localparam int unsigned NumBases = 7;
  localparam int unsigned BaseIdxW = 3;
  // Width of the multiplier bit counter and of the squaring counter.
  localparam int unsigned CntW = 6;

  // Request to the shared modular multiplier.
  typedef struct packed {
    logic             start;
    logic [CandW-1:0] op_a;
    logic [CandW-1:0] op_b;
  } mm_req_t;

  // Fixed witness bases of the deterministic 64-bit test.
  function automatic logic [BaseW-1:0] witness_base(input logic [BaseIdxW-1:0] idx);
    logic [BaseW-1:0] b;
    case (idx)
      3'd0:    b = 31'd2;
      3'd1:    b = 31'd325;
      3'd2:    b = 31'd9375;
      3'd3:    b = 31'd28178;
      3'd4:    b = 31'd450775;
      3'd5:    b = 31'd9780504;
      3'd6:    b = 31'd1795265022;
      default: b = 31'd2;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/mrpt_modmul.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes (op_a * op_b) mod m, most significant bit of op_b first, with one
// conditional add and reduce per cycle. Requires op_a < m.
// ----------------------------------------------------------------------------
module mrpt_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mrpt_pkg::mm_req_t          req_i,
  input  logic [mrpt_pkg::CandW-1:0] mod_i,
  output logic                       done_o,
  output logic [mrpt_pkg::CandW-1:0] res_o
);

  localparam int unsigned W = mrpt_pkg::CandW;
  localparam logic [mrpt_pkg::CntW-1:0] LastBit = mrpt_pkg::CntW'(W - 1);

  logic             busy_q, busy_d;
  logic             phase_q, phase_d;
  logic             done_q, done_d;
  logic [mrpt_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     m_q, m_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     addend;
  logic [W:0]       sum;
  logic [W:0]       diff;
  logic [W-1:0]     red;

  // Phase 0 doubles the accumulator, phase 1 adds op_a when the bit is set.
  // Both operands are below m, so one subtraction brings the sum below m.
  always_comb begin
    addend = phase_q ? (b_q[W-1] ? a_q : '0) : acc_q;
    sum    = {1'b0, acc_q} + {1'b0, addend};
    diff   = sum - {1'b0, m_q};
    red    = (sum >= {1'b0, m_q}) ? diff[W-1:0] : sum[W-1:0];
  end

  // Sequencing of the bit steps.
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    m_d     = m_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = '0;
      a_d     = req_i.op_a;
      b_d     = req_i.op_b;
      m_d     = mod_i;
      acc_d   = '0;
    end else if (busy_q) begin
      acc_d   = red;
      phase_d = ~phase_q;
      if (phase_q) begin
        b_d   = {b_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: hdl/miller_rabin_prime_test_unit.sv
// A candidate below 3 or even goes straight to S_DONE once taken; otherwise
// each of the seven bases needs one modular multiplication for the reduction
// plus those for the power and the squarings, all on the bit-serial multiplier.
// Throughput: one item at a time; a new item is taken once the last is done.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit
// Deterministic primality test of a 63-bit candidate with seven witness
// bases, built around one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mrpt_pkg::CandW-1:0] candidate_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_prime_o
);

  localparam int unsigned W = mrpt_pkg::CandW;
  localparam logic [mrpt_pkg::BaseIdxW-1:0] LastBase =
    mrpt_pkg::BaseIdxW'(mrpt_pkg::NumBases - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SPLIT = 12'b000000000010,
    S_RED   = 12'b000000000100,
    S_REDW  = 12'b000000001000,
    S_PCHK  = 12'b000000010000,
    S_PMULW = 12'b000000100000,
    S_PSQI  = 12'b000001000000,
    S_PSQW  = 12'b000010000000,
    S_SQCHK = 12'b000100000000,
    S_SQW   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [W-1:0] x_q, x_d;
  logic [W-1:0] odd_q, odd_d;
  logic [W-1:0] e_q, e_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] acc_q, acc_d;
  logic [mrpt_pkg::CntW-1:0] t_q, t_d;
  logic [mrpt_pkg::CntW-1:0] tc_q, tc_d;
  logic [mrpt_pkg::BaseIdxW-1:0] idx_q, idx_d;
  logic prime_q, prime_d;
  logic out_valid_q, out_valid_d;
  logic is_prime_q, is_prime_d;

  mrpt_pkg::mm_req_t mm_req;
  logic              mm_done;
  logic [W-1:0]      mm_res;

  // Shared modular multiplier.
  mrpt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .mod_i  (x_q),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: split, reduce base, power, squarings, next base.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    odd_d       = odd_q;
    e_d         = e_q;
    base_d      = base_q;
    acc_d       = acc_q;
    t_d         = t_q;
    tc_d        = tc_q;
    idx_d       = idx_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    mm_req      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d   = candidate_i;
          odd_d = candidate_i - W'(1);
          t_d   = '0;
          idx_d = '0;
          if (candidate_i <= W'(2) || !candidate_i[0]) begin
            prime_d = (candidate_i == W'(2));
            state_d = S_DONE;
          end else begin
            state_d = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (odd_q[0]) begin
          state_d = S_RED;
        end else begin
          odd_d = {1'b0, odd_q[W-1:1]};
          t_d   = t_q + 1'b1;
        end
      end
      S_RED: begin
        mm_req.start = 1'b1;
        mm_req.op_a  = W'(1);
        mm_req.op_b  = W'(mrpt_pkg::witness_base(idx_q));
        state_d      = S_REDW;
      end
      S_REDW: begin
        if (mm_done) begin
          base_d  = mm_res;
          acc_d   = W'(1);
          e_d     = odd_q;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (e_q == '0) begin
          tc_d    = t_q;
          state_d = S_SQCHK;
        end else if (e_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.op_a  = acc_q;
          mm_req.op_b  = base_q;
          state_d      = S_PMULW;
        end else begin
          state_d = S_PSQI;
        end
      end
      S_PMULW: begin
        if (mm_done) begin
          acc_d   = mm_res;
          state_d = S_PSQI;
        end
      end
      S_PSQI: begin
        mm_req.start = 1'b1;
        mm_req.op_a  = base_q;
        mm_req.op_b  = base_q;
        state_d      = S_PSQW;
      end
      S_PSQW: begin
        if (mm_done) begin
          base_d  = mm_res;
          e_d     = {1'b0, e_q[W-1:1]};
          state_d = S_PCHK;
        end
      end
      S_SQCHK: begin
        if (tc_q == '0) begin
          state_d = S_FIN;
        end else begin
          tc_d         = tc_q - 1'b1;
          mm_req.start = 1'b1;
          mm_req.op_a  = acc_q;
          mm_req.op_b  = acc_q;
          state_d      = S_SQW;
        end
      end
      S_SQW: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            state_d = S_FIN;
          end else if (mm_res == W'(1) && acc_q != W'(1) && acc_q != (x_q - W'(1))) begin
            // A nontrivial square root of one proves the candidate composite.
            prime_d = 1'b0;
            state_d = S_DONE;
          end else begin
            acc_d   = mm_res;
            state_d = S_SQCHK;
          end
        end
      end
      S_FIN: begin
        if (acc_q > W'(1)) begin
          prime_d = 1'b0;
          state_d = S_DONE;
        end else if (idx_q == LastBase) begin
          prime_d = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RED;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          is_prime_d  = prime_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      t_q         <= '0;
      tc_q        <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      t_q         <= t_d;
      tc_q        <= tc_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    odd_q      <= odd_d;
    e_q        <= e_d;
    base_q     <= base_d;
    acc_q      <= acc_d;
    prime_q    <= prime_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

`ifndef SYNTHESIS
  // The multiplier finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_REDW || state_q == S_PMULW ||
                 state_q == S_PSQW || state_q == S_SQW))
    else $error("multiplier result arrived outside a wait state");

  // An even candidate other than two is declared composite at once.
  a_even_composite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !candidate_i[0] && candidate_i != W'(2))
      |=> (state_q == S_DONE && !prime_q))
    else $error("even candidate not flagged composite");

  // The squaring count never exceeds the power of two in candidate minus one.
  a_sq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQCHK || state_q == S_SQW) |-> (tc_q <= t_q))
    else $error("squaring counter out of range");
`endif

endmodule
